@@ rtl/aes_pkg.sv @@
package aes_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW = 64;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_e;

  typedef logic [BlockW-1:0] block_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
      8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
      8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
      8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
      8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
      8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
      8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
      8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
      8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
      8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
      8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
      8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
      8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
      8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
      8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
      8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
      8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
      8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
      8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
      8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
      8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
      8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
      8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
      8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
      8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
      8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
      8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
      8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
      8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
      8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
      8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
      8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
      8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
      8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
      8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
      8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
      8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
      8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
      8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
      8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
      8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
      8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
      8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
      8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
      8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
      8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
      8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
      8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
      8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
      8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
      8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
      8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
      8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
      8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
      8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
      8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
      8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
      8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
      8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
      8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
      8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
      8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
      8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
      8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte n of the state sits in bits 127-8n downto 120-8n.
  function automatic logic [7:0] get_byte(input block_t s, input int n);
    return s[BlockW-1-8*n -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[BlockW-1-8*(4*c+r) -: 8] = sbox(get_byte(s, 4*((c+r)%4)+r));
      end
    end
    return o;
  endfunction

  function automatic block_t mix_cols(input block_t s);
    block_t o;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      o[BlockW-1-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      o[BlockW-1-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      o[BlockW-1-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      o[BlockW-1-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return o;
  endfunction

  // One step of the key schedule: next four words from the last four.
  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    block_t o;
    logic [31:0] t;
    t = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    o[127:96] = k[127:96] ^ t;
    o[95:64]  = k[95:64] ^ o[127:96];
    o[63:32]  = k[63:32] ^ o[95:64];
    o[31:0]   = k[31:0] ^ o[63:32];
    return o;
  endfunction

  function automatic logic [7:0] rcon(input int r);
    logic [7:0] v;
    v = 8'h01;
    for (int i = 1; i < 10; i++) begin
      if (i < r) begin
        v = xtime(v);
      end
    end
    return v;
  endfunction

endpackage

@@ rtl/aes_round.sv @@
// One pipeline stage: a cipher round on the state beside one key-schedule step.
module aes_round #(
  parameter int unsigned Round     = 1,
  parameter bit          LastRound = 1'b0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  aes_pkg::block_t state_i,
  input  aes_pkg::block_t key_i,
  output logic            valid_o,
  output aes_pkg::block_t state_o,
  output aes_pkg::block_t key_o
);
  import aes_pkg::*;

  localparam logic [7:0] Rc = rcon(Round);

  logic   valid_q;
  block_t state_d, state_q, key_d, key_q, ss;

  always_comb begin
    key_d = next_key(key_i, Rc);
    ss = sub_shift(state_i);
    if (LastRound) begin
      state_d = ss ^ key_d;
    end else begin
      state_d = mix_cols(ss) ^ key_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule

@@ rtl/aes128_block_encrypt.sv @@
// AES-128 encryption engine, fully unrolled and pipelined.
// Load the cipher key through the write port (index 0 upper key half, index 1
// lower half) while no item is in flight; a new key applies to items started
// after the write. Both halves reset to zero.
// An item is accepted on a clock edge with start_i high; busy_o is always low,
// so one block can be taken in every cycle.
// One register follows the initial key addition and one follows each round,
// each round stage holding the state and its round key side by side. The
// ciphertext appears on cipher_high_o/cipher_low_o for one cycle with done_o
// high. Results cannot be held off; they leave in input order.
// Reset clears all valid bits, so items in flight are dropped.
module aes128_block_encrypt #(
  parameter int unsigned ROUNDS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [aes_pkg::HalfW-1:0] block_high_i,
  input  logic [aes_pkg::HalfW-1:0] block_low_i,
  output logic                    done_o,
  output logic [aes_pkg::HalfW-1:0] cipher_high_o,
  output logic [aes_pkg::HalfW-1:0] cipher_low_o,
  input  logic                    cfg_we_i,
  input  logic [0:0]              cfg_idx_i,
  input  logic [aes_pkg::HalfW-1:0] cfg_data_i
);
  import aes_pkg::*;

  logic [HalfW-1:0] key_high_q, key_low_q;
  logic             v [ROUNDS+1];
  block_t           st [ROUNDS+1];
  block_t           ky [ROUNDS+1];
  logic             v0_q;
  block_t           st0_q, ky0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      st0_q <= {block_high_i, block_low_i} ^ {key_high_q, key_low_q};
      ky0_q <= {key_high_q, key_low_q};
    end
  end

  assign v[0]  = v0_q;
  assign st[0] = st0_q;
  assign ky[0] = ky0_q;

  for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
    aes_round #(
      .Round     (r),
      .LastRound (r == ROUNDS)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[r-1]),
      .state_i (st[r-1]),
      .key_i   (ky[r-1]),
      .valid_o (v[r]),
      .state_o (st[r]),
      .key_o   (ky[r])
    );
  end

  assign busy_o        = 1'b0;
  assign done_o        = v[ROUNDS];
  assign cipher_high_o = st[ROUNDS][BlockW-1:HalfW];
  assign cipher_low_o  = st[ROUNDS][HalfW-1:0];

endmodule
